FILE: sv/rc_serial_frame_channel_decoder_assert.svh
// assertion macros shared by the frame decoder modules
`ifndef RC_SERIAL_FRAME_CHANNEL_DECODER_ASSERT_SVH
`define RC_SERIAL_FRAME_CHANNEL_DECODER_ASSERT_SVH
// same-cycle implication
`define RCFD_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rcfd: same-cycle check failed");
// next-cycle implication
`define RCFD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rcfd: next-cycle check failed");
`endif

FILE: sv/rcfd_pkg.sv
// types and constants of the serial frame channel decoder
package rcfd_pkg;

    localparam int NUM_CHANNELS_DEF    = 12;
    localparam int FRAME_BYTES_DEF     = 16;
    localparam int SLOTS_PER_FRAME_DEF = 7;
    localparam int QUEUE_DEPTH         = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0,
        REQ_TICK = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [7:0]  arg;
        logic        idx_ok;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_CODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_FRAME    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_HEADER_MASK = 3'd5;

    localparam logic [1:0]  PROTOCOL_MODE_RST = 2'd0;
    localparam logic [7:0]  GAP_TICKS_RST     = 8'd4;
    localparam logic [7:0]  FAILSAFE_RST      = 8'd64;
    localparam logic [15:0] TIMEOUT_CODE_RST  = 16'hfffe;
    localparam logic [15:0] SECOND_FRAME_RST  = 16'h8000;
    localparam logic [7:0]  RES_HDR_MASK_RST  = 8'h10;

    localparam logic [1:0] MODE_DSM2     = 2'd0;
    localparam logic [1:0] MODE_DSMX_10  = 2'd1;
    localparam logic [1:0] MODE_DSMX_11  = 2'd2;

    localparam logic [7:0] HDR_DSM2_A = 8'h01;
    localparam logic [7:0] HDR_DSM2_B = 8'h02;
    localparam logic [7:0] HDR_DSM2_C = 8'h12;
    localparam logic [7:0] HDR_DSMX_A = 8'ha2;
    localparam logic [7:0] HDR_DSMX_B = 8'hb2;

    localparam logic [15:0] EMPTY_SLOT = 16'hffff;
    localparam logic [15:0] MASK_10BIT = 16'h03ff;
    localparam logic [15:0] MASK_11BIT = 16'h07ff;

    localparam logic [1:0] ST_READ_OK      = 2'd0;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd1;
    localparam logic [1:0] ST_NOT_READ     = 2'd2;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_ACCEPT = 2'd1;
    localparam logic [1:0] EV_REJECT = 2'd2;

endpackage

FILE: sv/rcfd_ram.sv
// generic single-write, single-read ram with registered read data
module rcfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/rcfd_front.sv
// input stage: takes a transfer and classifies it into a command
module rcfd_front import rcfd_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_data_byte,
    input  logic [7:0] s_channel_index,
    input  q_stat_t    q_stat,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam logic [7:0] NUM_CH_W8 = 8'(NUM_CHANNELS);

    logic hold_valid_reg, hold_valid_next;
    cmd_t hold_cmd_reg, hold_cmd_next;
    cmd_t in_cmd;
    logic accept;

    always_comb begin
        in_cmd.kind   = req_kind_t'(s_req_type);
        in_cmd.arg    = (in_cmd.kind == REQ_READ) ? s_channel_index : s_data_byte;
        in_cmd.idx_ok = (s_channel_index < NUM_CH_W8);
    end

    assign push    = hold_valid_reg && !q_stat.full;
    assign s_ready = !hold_valid_reg || !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign push_cmd = hold_cmd_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
            hold_cmd_next   = in_cmd;
        end else if (push) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

FILE: sv/rcfd_queue.sv
// short command queue between the front and back stages
`include "rc_serial_frame_channel_decoder_assert.svh"
module rcfd_queue import rcfd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head_cmd,
    output q_stat_t stat
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `RCFD_ASSERT_NOW(a_q_no_overflow, push, !stat.full)
    `RCFD_ASSERT_NOW(a_q_no_underflow, pop, !stat.empty)

endmodule

FILE: sv/rcfd_back.sv
// execution stage: counters, frame capture and decode, channel store, result register
`include "rc_serial_frame_channel_decoder_assert.svh"
module rcfd_back import rcfd_pkg::*; #(
    parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
    parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
    parameter int SLOTS_PER_FRAME = SLOTS_PER_FRAME_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  cmd_t                  q_cmd,
    input  q_stat_t               q_stat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_channel_value,
    output logic [1:0]            m_read_status,
    output logic [1:0]            m_frame_event,
    output logic                  m_channels_cleared
);

    localparam int FIT    = (FRAME_BYTES - 2) / 2;
    localparam int SLOTS  = (SLOTS_PER_FRAME < FIT) ? SLOTS_PER_FRAME : FIT;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BUF_AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int POS_W  = $clog2(FRAME_BYTES + 1);
    localparam int CH_AW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [POS_W-1:0]  POS_END   = POS_W'(FRAME_BYTES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [BUF_AW-1:0] HDR_ADDR  = BUF_AW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_CHK,
        S_HI,
        S_LO,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  gap_reg, gap_next;
    logic [7:0]  fs_lim_reg, fs_lim_next;
    logic [15:0] tcode_reg, tcode_next;
    logic [15:0] sfm_reg, sfm_next;
    logic [7:0]  rhm_reg, rhm_next;

    logic [15:0]       store_reg [NUM_CHANNELS];
    logic [15:0]       store_next [NUM_CHANNELS];
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              armed_reg, armed_next;
    logic [7:0]        idle_cnt_reg, idle_cnt_next;
    logic [7:0]        fs_cnt_reg, fs_cnt_next;
    logic              res11_reg, res11_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [7:0]        hi_reg, hi_next;

    logic [15:0] pend_value_reg, pend_value_next;
    logic [1:0]  pend_status_reg, pend_status_next;
    logic [1:0]  pend_event_reg, pend_event_next;
    logic        pend_cleared_reg, pend_cleared_next;

    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_value_reg, m_value_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [1:0]  m_event_reg, m_event_next;
    logic        m_cleared_reg, m_cleared_next;

    logic              ram_we;
    logic [BUF_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic decoding;
    logic resp_load;

    rcfd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pos_reg[BUF_AW-1:0]),
        .wdata (q_cmd.arg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        logic [15:0]       word;
        logic [3:0]        ch;
        logic [7:0]        hdr;
        logic              hdr_ok;
        logic              hdr_res11;
        logic [7:0]        idle_inc;
        logic [7:0]        fs_inc;
        logic [POS_W-1:0]  pos_inc;
        logic [BUF_AW-1:0] slot_ext;
        logic              out_free;

        state_next        = state_reg;
        mode_next         = mode_reg;
        gap_next          = gap_reg;
        fs_lim_next       = fs_lim_reg;
        tcode_next        = tcode_reg;
        sfm_next          = sfm_reg;
        rhm_next          = rhm_reg;
        store_next        = store_reg;
        pos_next          = pos_reg;
        armed_next        = armed_reg;
        idle_cnt_next     = idle_cnt_reg;
        fs_cnt_next       = fs_cnt_reg;
        res11_next        = res11_reg;
        slot_next         = slot_reg;
        hi_next           = hi_reg;
        pend_value_next   = pend_value_reg;
        pend_status_next  = pend_status_reg;
        pend_event_next   = pend_event_reg;
        pend_cleared_next = pend_cleared_reg;
        m_value_next      = m_value_reg;
        m_status_next     = m_status_reg;
        m_event_next      = m_event_reg;
        m_cleared_next    = m_cleared_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        pop               = 1'b0;
        ram_we            = 1'b0;
        ram_raddr         = HDR_ADDR;

        word      = {hi_reg, ram_rdata};
        ch        = res11_reg ? word[14:11] : word[13:10];
        hdr       = ram_rdata;
        idle_inc  = idle_cnt_reg + 8'd1;
        fs_inc    = fs_cnt_reg + 8'd1;
        pos_inc   = pos_reg + 1'b1;
        slot_ext  = BUF_AW'(slot_reg);
        out_free  = !m_valid_reg || m_ready;
        hdr_ok    = 1'b0;
        hdr_res11 = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                CFG_PROTOCOL_MODE:   mode_next   = cfg_wdata[1:0];
                CFG_GAP_TICKS:       gap_next    = cfg_wdata[7:0];
                CFG_FAILSAFE_TICKS:  fs_lim_next = cfg_wdata[7:0];
                CFG_TIMEOUT_CODE:    tcode_next  = cfg_wdata;
                CFG_SECOND_FRAME:    sfm_next    = cfg_wdata;
                CFG_RES_HEADER_MASK: rhm_next    = cfg_wdata[7:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (!q_stat.empty) begin
                    pop               = 1'b1;
                    pend_value_next   = '0;
                    pend_status_next  = ST_NOT_READ;
                    pend_event_next   = EV_NONE;
                    pend_cleared_next = 1'b0;
                    state_next        = S_RESP;
                    case (q_cmd.kind)
                        REQ_BYTE: begin
                            idle_cnt_next = '0;
                            if (armed_reg && pos_reg < POS_END) begin
                                ram_we   = 1'b1;
                                pos_next = pos_inc;
                                if (pos_inc == POS_END) begin
                                    armed_next = 1'b0;
                                    state_next = S_HDR;
                                end
                            end
                        end
                        REQ_TICK: begin
                            if (idle_inc > gap_reg) begin
                                armed_next    = 1'b1;
                                pos_next      = '0;
                                idle_cnt_next = '0;
                            end else begin
                                idle_cnt_next = idle_inc;
                            end
                            if (fs_inc > fs_lim_reg) begin
                                for (int i = 0; i < NUM_CHANNELS; i++) begin
                                    store_next[i] = tcode_reg;
                                end
                                fs_cnt_next       = '0;
                                pend_cleared_next = 1'b1;
                            end else begin
                                fs_cnt_next = fs_inc;
                            end
                        end
                        REQ_READ: begin
                            if (q_cmd.idx_ok) begin
                                pend_value_next  = store_reg[q_cmd.arg[CH_AW-1:0]];
                                pend_status_next = ST_READ_OK;
                            end else begin
                                pend_status_next = ST_OUT_OF_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_HDR: begin
                ram_raddr  = HDR_ADDR;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (hdr == HDR_DSM2_A || hdr == HDR_DSM2_B || hdr == HDR_DSM2_C) begin
                    hdr_ok    = (mode_reg == MODE_DSM2);
                    hdr_res11 = |(hdr & rhm_reg);
                end else if (hdr == HDR_DSMX_A || hdr == HDR_DSMX_B) begin
                    hdr_ok    = (mode_reg == MODE_DSMX_10) || (mode_reg == MODE_DSMX_11);
                    hdr_res11 = (mode_reg == MODE_DSMX_11);
                end
                if (hdr_ok) begin
                    res11_next = hdr_res11;
                    slot_next  = '0;
                    ram_raddr  = BUF_AW'(2);
                    state_next = S_HI;
                end else begin
                    pend_event_next = EV_REJECT;
                    state_next      = S_RESP;
                end
            end
            S_HI: begin
                hi_next    = ram_rdata;
                ram_raddr  = (slot_ext << 1) + BUF_AW'(3);
                state_next = S_LO;
            end
            S_LO: begin
                if (word != EMPTY_SLOT && slot_reg != '0 && |(word & sfm_reg)) begin
                    pend_event_next = EV_REJECT;
                    state_next      = S_RESP;
                end else begin
                    if (word != EMPTY_SLOT) begin
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            if (ch == 4'(i)) begin
                                store_next[i] = word & (res11_reg ? MASK_11BIT : MASK_10BIT);
                            end
                        end
                    end
                    if (slot_reg == SLOT_LAST) begin
                        pend_event_next = EV_ACCEPT;
                        fs_cnt_next     = '0;
                        state_next      = S_RESP;
                    end else begin
                        slot_next  = slot_reg + 1'b1;
                        ram_raddr  = ((slot_ext + 1'b1) << 1) + BUF_AW'(2);
                        state_next = S_HI;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_value_next   = pend_value_reg;
                    m_status_next  = pend_status_reg;
                    m_event_next   = pend_event_reg;
                    m_cleared_next = pend_cleared_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= PROTOCOL_MODE_RST;
            gap_reg      <= GAP_TICKS_RST;
            fs_lim_reg   <= FAILSAFE_RST;
            tcode_reg    <= TIMEOUT_CODE_RST;
            sfm_reg      <= SECOND_FRAME_RST;
            rhm_reg      <= RES_HDR_MASK_RST;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                store_reg[i] <= TIMEOUT_CODE_RST;
            end
            pos_reg      <= '0;
            armed_reg    <= 1'b0;
            idle_cnt_reg <= '0;
            fs_cnt_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            gap_reg      <= gap_next;
            fs_lim_reg   <= fs_lim_next;
            tcode_reg    <= tcode_next;
            sfm_reg      <= sfm_next;
            rhm_reg      <= rhm_next;
            store_reg    <= store_next;
            pos_reg      <= pos_next;
            armed_reg    <= armed_next;
            idle_cnt_reg <= idle_cnt_next;
            fs_cnt_reg   <= fs_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        res11_reg        <= res11_next;
        slot_reg         <= slot_next;
        hi_reg           <= hi_next;
        pend_value_reg   <= pend_value_next;
        pend_status_reg  <= pend_status_next;
        pend_event_reg   <= pend_event_next;
        pend_cleared_reg <= pend_cleared_next;
        m_value_reg      <= m_value_next;
        m_status_reg     <= m_status_next;
        m_event_reg      <= m_event_next;
        m_cleared_reg    <= m_cleared_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_channel_value    = m_value_reg;
    assign m_read_status      = m_status_reg;
    assign m_frame_event      = m_event_reg;
    assign m_channels_cleared = m_cleared_reg;

    assign decoding  = (state_reg == S_HDR) || (state_reg == S_CHK) ||
                       (state_reg == S_HI) || (state_reg == S_LO);
    assign resp_load = (state_reg == S_RESP) && (!m_valid_reg || m_ready);

    `RCFD_ASSERT_NOW(a_armed_pos_in_frame, armed_reg, pos_reg < POS_END)
    `RCFD_ASSERT_NOW(a_decode_disarmed, decoding, !armed_reg)
    `RCFD_ASSERT_NEXT(a_resp_loads_output, resp_load, m_valid_reg && state_reg == S_IDLE)
    `RCFD_ASSERT_NOW(a_pop_only_idle, pop, state_reg == S_IDLE)

endmodule

FILE: sv/rc_serial_frame_channel_decoder.sv
// top level of the serial frame channel decoder
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  input    | s_valid / s_ready  | s_req_type, s_data_byte, s_channel_index
//  result   | m_valid / m_ready  | m_channel_value, m_read_status, m_frame_event,
//           |                    | m_channels_cleared
//  config   | cfg_we             | cfg_index, cfg_wdata
//
//  a transfer passes an input register and a two-entry queue, then the execution fsm
//  ticks, reads and non-frame bytes pass from the idle to the response state; a frame's
//  last byte also takes a header read and check, then up to a high and a low read per slot on
//  the one buffer read port; reset is synchronous, the channel store gets the timeout code
//  the result register holds while m_ready is low, the queue keeps taking input until full
module rc_serial_frame_channel_decoder import rcfd_pkg::*; #(
    parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
    parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
    parameter int SLOTS_PER_FRAME = SLOTS_PER_FRAME_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [7:0]            s_data_byte,
    input  logic [7:0]            s_channel_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_channel_value,
    output logic [1:0]            m_read_status,
    output logic [1:0]            m_frame_event,
    output logic                  m_channels_cleared,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    q_stat_t q_stat;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    head_cmd;

    rcfd_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_data_byte     (s_data_byte),
        .s_channel_index (s_channel_index),
        .q_stat          (q_stat),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    rcfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    rcfd_back #(
        .NUM_CHANNELS    (NUM_CHANNELS),
        .FRAME_BYTES     (FRAME_BYTES),
        .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .q_cmd              (head_cmd),
        .q_stat             (q_stat),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_channel_value    (m_channel_value),
        .m_read_status      (m_read_status),
        .m_frame_event      (m_frame_event),
        .m_channels_cleared (m_channels_cleared)
    );

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the serial frame channel decoder
module tb_top;
    import rcfd_pkg::*;

    localparam int NCH = NUM_CHANNELS_DEF;
    localparam int FB = FRAME_BYTES_DEF;
    localparam int SPF = SLOTS_PER_FRAME_DEF;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        req_kind_t  kind;
        logic [7:0] data;
        logic [7:0] idx;
    } req_item_t;

    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  status;
        logic [1:0]  frame_ev;
        logic        cleared;
    } dec_out_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_req_type = REQ_NONE;
    logic [7:0]            s_data_byte = 8'd0;
    logic [7:0]            s_channel_index = 8'd0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [15:0]           m_channel_value;
    logic [1:0]            m_read_status;
    logic [1:0]            m_frame_event;
    logic                  m_channels_cleared;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PROTOCOL_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    rc_serial_frame_channel_decoder u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_data_byte        (s_data_byte),
        .s_channel_index    (s_channel_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_channel_value    (m_channel_value),
        .m_read_status      (m_read_status),
        .m_frame_event      (m_frame_event),
        .m_channels_cleared (m_channels_cleared),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // decoder shadow state
    logic [1:0]  cfg_mode = PROTOCOL_MODE_RST;
    logic [7:0]  cfg_gap = GAP_TICKS_RST;
    logic [7:0]  cfg_fs = FAILSAFE_RST;
    logic [15:0] cfg_tcode = TIMEOUT_CODE_RST;
    logic [15:0] cfg_sfm = SECOND_FRAME_RST;
    logic [7:0]  cfg_rhm = RES_HDR_MASK_RST;
    logic [15:0] chan_store [NCH];
    logic [7:0]  frame_buf [FB];
    logic [4:0]  byte_pos = 5'd0;
    logic        armed = 1'b0;
    logic [7:0]  idle_cnt = 8'd0;
    logic [7:0]  fs_cnt = 8'd0;

    req_item_t   tx_items [$];
    dec_out_t    decoded_q [$];
    req_item_t   cur_item;
    logic [15:0] slot_word [SPF];
    int          n_items = 0;
    int          mismatches = 0;
    int          idle_pct = 15;
    int          quiet_cycles = 0;

    function automatic bit decode_frame_buf();
        logic [7:0]  hdr;
        logic [15:0] word;
        logic [15:0] vmask;
        logic [3:0]  ch;
        int          res;
        int          nslots;
        int          s;
        hdr = frame_buf[1];
        if (hdr == HDR_DSM2_A || hdr == HDR_DSM2_B || hdr == HDR_DSM2_C) begin
            if (cfg_mode != MODE_DSM2)
                return 1'b0;
            res = ((hdr & cfg_rhm) != 8'd0) ? 11 : 10;
        end else if (hdr == HDR_DSMX_A || hdr == HDR_DSMX_B) begin
            if (cfg_mode == MODE_DSMX_10)
                res = 10;
            else if (cfg_mode == MODE_DSMX_11)
                res = 11;
            else
                return 1'b0;
        end else begin
            return 1'b0;
        end
        vmask = (res == 10) ? MASK_10BIT : MASK_11BIT;
        nslots = (SPF < (FB - 2) / 2) ? SPF : (FB - 2) / 2;
        for (s = 0; s < nslots; s++) begin
            word = {frame_buf[2 + 2 * s], frame_buf[3 + 2 * s]};
            if (word != EMPTY_SLOT) begin
                // partial frame: earlier slots stay stored
                if (s > 0 && (word & cfg_sfm) != 16'd0)
                    return 1'b0;
                ch = word[res +: 4];
                if (ch < NCH)
                    chan_store[ch] = word & vmask;
            end
        end
        return 1'b1;
    endfunction

    function automatic dec_out_t decode_step(req_item_t it);
        dec_out_t o;
        o = '{value: 16'd0, status: ST_NOT_READ, frame_ev: EV_NONE, cleared: 1'b0};
        case (it.kind)
            REQ_BYTE: begin
                if (armed && byte_pos < FB) begin
                    frame_buf[byte_pos] = it.data;
                    byte_pos = byte_pos + 5'd1;
                    if (byte_pos == FB) begin
                        if (decode_frame_buf()) begin
                            fs_cnt = 8'd0;
                            o.frame_ev = EV_ACCEPT;
                        end else begin
                            o.frame_ev = EV_REJECT;
                        end
                        armed = 1'b0;
                    end
                end
                idle_cnt = 8'd0;
            end
            REQ_TICK: begin
                idle_cnt = idle_cnt + 8'd1;
                if (idle_cnt > cfg_gap) begin
                    armed = 1'b1;
                    byte_pos = 5'd0;
                    idle_cnt = 8'd0;
                end
                fs_cnt = fs_cnt + 8'd1;
                if (fs_cnt > cfg_fs) begin
                    foreach (chan_store[i])
                        chan_store[i] = cfg_tcode;
                    fs_cnt = 8'd0;
                    o.cleared = 1'b1;
                end
            end
            REQ_READ: begin
                if (it.idx < NCH) begin
                    o.value = chan_store[it.idx];
                    o.status = ST_READ_OK;
                end else begin
                    o.status = ST_OUT_OF_RANGE;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // input channel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                decoded_q.push_back(decode_step(cur_item));
            if (!s_valid || s_ready) begin
                if (tx_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_item = tx_items.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= cur_item.kind;
                    s_data_byte <= cur_item.data;
                    s_channel_index <= cur_item.idx;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // result channel monitor
    always @(posedge aclk) begin
        dec_out_t want;
        m_ready <= ($urandom_range(99) >= idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer, expected none actual %h %0d %0d %0d",
                         $time, m_channel_value, m_read_status, m_frame_event,
                         m_channels_cleared);
            end else begin
                want = decoded_q.pop_front();
                check_field("channel_value", want.value, m_channel_value);
                check_field("read_status", 16'(want.status), 16'(m_read_status));
                check_field("frame_event", 16'(want.frame_ev), 16'(m_frame_event));
                check_field("channels_cleared", 16'(want.cleared), 16'(m_channels_cleared));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic push_item(req_kind_t kind, logic [7:0] data, logic [7:0] idx);
        tx_items.push_back('{kind: kind, data: data, idx: idx});
        n_items++;
    endtask

    task automatic push_tick();
        push_item(REQ_TICK, 8'($urandom), 8'($urandom));
    endtask

    task automatic push_read(logic [7:0] idx);
        push_item(REQ_READ, 8'($urandom), idx);
    endtask

    task automatic arm_decoder();
        repeat (int'(cfg_gap) + 1) push_tick();
    endtask

    task automatic push_frame(logic [7:0] hdr, int nbytes, bit noisy);
        logic [7:0] b;
        int         k;
        for (k = 0; k < nbytes; k++) begin
            if (k == 0)
                b = 8'($urandom);
            else if (k == 1)
                b = hdr;
            else if (k % 2 == 0)
                b = slot_word[(k - 2) / 2][15:8];
            else
                b = slot_word[(k - 2) / 2][7:0];
            if (noisy && $urandom_range(49) == 0)
                push_tick();
            push_item(REQ_BYTE, b, 8'($urandom));
        end
    endtask

    task automatic fill_random_slots();
        int s;
        for (s = 0; s < SPF; s++) begin
            if ($urandom_range(99) < 12) begin
                slot_word[s] = EMPTY_SLOT;
            end else begin
                slot_word[s] = 16'($urandom);
                if (s > 0 && $urandom_range(99) < 92)
                    slot_word[s] = slot_word[s] & ~cfg_sfm;
            end
        end
    endtask

    function automatic logic [7:0] pick_header();
        int r;
        bit dsm2;
        r = $urandom_range(9);
        if (r == 0)
            return 8'($urandom);
        dsm2 = (cfg_mode == MODE_DSM2);
        if (r == 1)
            dsm2 = !dsm2;
        if (dsm2) begin
            case ($urandom_range(2))
                0: return HDR_DSM2_A;
                1: return HDR_DSM2_B;
                default: return HDR_DSM2_C;
            endcase
        end
        return $urandom_range(1) ? HDR_DSMX_A : HDR_DSMX_B;
    endfunction

    function automatic logic [7:0] pick_index();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    endfunction

    task automatic random_episode();
        int r;
        int nb;
        r = $urandom_range(99);
        if (r < 65) begin
            arm_decoder();
            fill_random_slots();
            nb = ($urandom_range(9) == 0) ? $urandom_range(1, FB - 1) : FB;
            push_frame(pick_header(), nb, 1'b1);
            repeat ($urandom_range(1, 3)) push_read(pick_index());
        end else if (r < 80) begin
            repeat ($urandom_range(1, 4)) push_read(pick_index());
        end else if (r < 92) begin
            repeat ($urandom_range(1, 8)) push_tick();
        end else begin
            repeat ($urandom_range(1, 3))
                push_item(req_kind_t'($urandom_range(3)), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PROTOCOL_MODE:   cfg_mode = val[1:0];
            CFG_GAP_TICKS:       cfg_gap = val[7:0];
            CFG_FAILSAFE_TICKS:  cfg_fs = val[7:0];
            CFG_TIMEOUT_CODE:    cfg_tcode = val;
            CFG_SECOND_FRAME:    cfg_sfm = val;
            CFG_RES_HEADER_MASK: cfg_rhm = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [1:0] mode, logic [7:0] gap, logic [7:0] fs,
                              logic [15:0] tcode, logic [15:0] sfm, logic [7:0] rhm);
        write_reg(CFG_PROTOCOL_MODE, 16'(mode));
        write_reg(CFG_GAP_TICKS, 16'(gap));
        write_reg(CFG_FAILSAFE_TICKS, 16'(fs));
        write_reg(CFG_TIMEOUT_CODE, tcode);
        write_reg(CFG_SECOND_FRAME, sfm);
        write_reg(CFG_RES_HEADER_MASK, 16'(rhm));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge aclk);
        while (tx_items.size() != 0 || s_valid || decoded_q.size() != 0);
        repeat (30) @(posedge aclk);
    endtask

    initial begin
        int          ph;
        int          goal;
        logic [15:0] sfm;
        foreach (chan_store[i])
            chan_store[i] = TIMEOUT_CODE_RST;
        foreach (frame_buf[i])
            frame_buf[i] = 8'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                wait_drained();
                idle_pct = (ph == 4) ? 0 : 15;
                case (ph)
                    1: set_config(MODE_DSMX_10, 8'd0, 8'd254, 16'h0000, 16'hffff, 8'hff);
                    2: set_config(MODE_DSMX_11, 8'd2, 8'd0, 16'($urandom), 16'h8000, 8'h10);
                    3: set_config(MODE_DSM2, 8'd254, 8'd254, 16'hffff, 16'h0000, 8'h00);
                    default: begin
                        sfm = $urandom_range(1) ? 16'(1 << $urandom_range(15)) : 16'($urandom);
                        set_config(2'($urandom_range(2)), 8'($urandom_range(6)),
                                   8'($urandom_range(80)), 16'($urandom), sfm, 8'($urandom));
                    end
                endcase
            end

            if (ph == 0) begin
                // reset contents, out-of-range reads, unused request, stray byte
                push_read(8'd0);
                push_read(8'(NCH));
                push_read(8'hff);
                push_item(REQ_NONE, 8'hff, 8'hff);
                push_item(REQ_BYTE, 8'hff, 8'h00);
                arm_decoder();
                // second-frame bit allowed in the first slot, channel above range dropped
                slot_word[0] = {1'b1, 4'd3, 11'h7ff};
                slot_word[1] = EMPTY_SLOT;
                slot_word[2] = {1'b0, 4'd13, 11'h123};
                slot_word[3] = {1'b0, 4'd11, 11'h000};
                slot_word[4] = {1'b0, 4'd0, 11'h7ff};
                slot_word[5] = EMPTY_SLOT;
                slot_word[6] = {1'b0, 4'd5, 11'h555};
                push_frame(HDR_DSM2_C, FB, 1'b0);
                push_read(8'd3);
                push_read(8'd11);
            end else if (ph == 1) begin
                // wrong header family, then a frame rejected after its first slot
                arm_decoder();
                push_frame(HDR_DSM2_B, FB, 1'b0);
                arm_decoder();
                slot_word[0] = {2'b00, 4'd7, 10'h2aa};
                slot_word[1] = {2'b00, 4'd2, 10'h155};
                push_frame(HDR_DSMX_A, FB, 1'b0);
                push_read(8'd7);
                push_read(8'd2);
            end else if (ph == 3) begin
                // longest gap and failsafe count
                arm_decoder();
                fill_random_slots();
                push_frame(HDR_DSM2_A, FB, 1'b0);
                for (int c = 0; c < 16; c++)
                    push_read(8'(c));
            end

            goal = n_items + ((ph == 3) ? 0 : 100);
            while (n_items < goal)
                random_episode();
        end

        wait_drained();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
